/* hdl/periodic_mesh_index_alu_core_assert.svh */
// assertion macros used by the checker of the mesh index unit
`ifndef PERIODIC_MESH_INDEX_ALU_CORE_ASSERT_SVH
`define PERIODIC_MESH_INDEX_ALU_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mesh index unit: implication failed");

// implication after a fixed number of cycles, held off during reset
`define PMI_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("mesh index unit: delayed implication failed");

`endif

/* hdl/pmi_pkg.sv */
`default_nettype none

package pmi_pkg;

    localparam int IDX_W       = 12;
    localparam int SIDE_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = IDX_W + RECIP_W;
    localparam int MUL_W       = IDX_W + SIDE_W;
    localparam int SXY_W       = 2 * SIDE_W;
    localparam int TOT_W       = 3 * SIDE_W;
    localparam int SUM_W       = TOT_W + 1;
    localparam int LATENCY     = 6;
    localparam int MAX_SIDE_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_NEG  = 2'd0,
        OP_DIFF = 2'd1,
        OP_SUM  = 2'd2,
        OP_BAD  = 2'd3
    } op_t;

    typedef struct packed {
        logic bad;
        op_t  op;
    } ctl_t;

    typedef struct packed {
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] z;
    } coord_t;

    // ceil(2^17 / d): exact quotient for 12-bit dividends and d up to 31
    function automatic logic [RECIP_W-1:0] recip_of(input logic [SIDE_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 18'd131072;
            5'd2:    r = 18'd65536;
            5'd3:    r = 18'd43691;
            5'd4:    r = 18'd32768;
            5'd5:    r = 18'd26215;
            5'd6:    r = 18'd21846;
            5'd7:    r = 18'd18725;
            5'd8:    r = 18'd16384;
            5'd9:    r = 18'd14564;
            5'd10:   r = 18'd13108;
            5'd11:   r = 18'd11916;
            5'd12:   r = 18'd10923;
            5'd13:   r = 18'd10083;
            5'd14:   r = 18'd9363;
            5'd15:   r = 18'd8739;
            5'd16:   r = 18'd8192;
            5'd17:   r = 18'd7711;
            5'd18:   r = 18'd7282;
            5'd19:   r = 18'd6899;
            5'd20:   r = 18'd6554;
            5'd21:   r = 18'd6242;
            5'd22:   r = 18'd5958;
            5'd23:   r = 18'd5699;
            5'd24:   r = 18'd5462;
            5'd25:   r = 18'd5243;
            5'd26:   r = 18'd5042;
            5'd27:   r = 18'd4855;
            5'd28:   r = 18'd4682;
            5'd29:   r = 18'd4520;
            5'd30:   r = 18'd4370;
            5'd31:   r = 18'd4229;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/periodic_mesh_index_alu_core.sv */
// periodic mesh index unit
// command channel: an operation (opcode, idx_a, idx_b, idx_c) transfers at a
// rising edge with start high and busy low; busy stays low, so one operation
// can transfer on every clock cycle.
// each operation gives exactly one result on result_index / invalid, shown
// for one cycle with done high. results leave in the order operations
// came.
// the latency is set by the coordinate split: a reciprocal multiply for the
// quotient by side_x, a multiply back for the remainder, then the same for
// side_y, followed by one stage of per-axis wrap and one of recombination.
// config port: cfg_we with cfg_index 0/1/2 writes side_x/side_y/side_z from
// cfg_wdata; a side of 0 reads as 1, one above MAX_SIDE as MAX_SIDE. write
// only while no operation is in flight.
// reset clears the in-flight valid bits and sets every side to 1.
// there is no backpressure: the receiver must take each result when shown.
`default_nettype none

module periodic_mesh_index_alu_core #(
    parameter int MAX_SIDE = pmi_pkg::MAX_SIDE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       opcode,
    input  wire logic [pmi_pkg::IDX_W-1:0]        idx_a,
    input  wire logic [pmi_pkg::IDX_W-1:0]        idx_b,
    input  wire logic [pmi_pkg::IDX_W-1:0]        idx_c,
    input  wire logic                             cfg_we,
    input  wire logic [pmi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pmi_pkg::SIDE_W-1:0]       cfg_wdata,
    output logic                                  done,
    output logic [pmi_pkg::IDX_W-1:0]             result_index,
    output logic                                  invalid
);

    logic                           accept;
    logic [pmi_pkg::SIDE_W-1:0]     side_x_reg, side_y_reg, side_z_reg;
    logic [pmi_pkg::SIDE_W-1:0]     side_eff;
    logic [pmi_pkg::SXY_W-1:0]      sxy_reg, sxy_next;
    logic [pmi_pkg::TOT_W-1:0]      tot_reg, tot_next;
    logic [pmi_pkg::RECIP_W-1:0]    recip_x, recip_y;
    logic [pmi_pkg::LATENCY-1:0]    valid_reg, valid_next;

    pmi_pkg::op_t                   op_s1_reg, op_s2_reg;
    logic [pmi_pkg::IDX_W-1:0]      a_s1_reg, b_s1_reg, c_s1_reg;
    logic [pmi_pkg::IDX_W-1:0]      a_s2_reg, b_s2_reg, c_s2_reg;
    pmi_pkg::ctl_t                  ctl_s3_reg, ctl_s3_next, ctl_s4_reg;
    pmi_pkg::coord_t                coord_a, coord_b, coord_c;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // clamp the written side into 1..MAX_SIDE
    always_comb
    begin
        if (cfg_wdata == '0)
            side_eff = pmi_pkg::SIDE_W'(1);
        else if (int'(cfg_wdata) > MAX_SIDE)
            side_eff = pmi_pkg::SIDE_W'(MAX_SIDE);
        else
            side_eff = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_x_reg <= pmi_pkg::SIDE_W'(1);
            side_y_reg <= pmi_pkg::SIDE_W'(1);
            side_z_reg <= pmi_pkg::SIDE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pmi_pkg::CFG_SIDE_X: side_x_reg <= side_eff;
                pmi_pkg::CFG_SIDE_Y: side_y_reg <= side_eff;
                pmi_pkg::CFG_SIDE_Z: side_z_reg <= side_eff;
                default:             ;
            endcase
        end
    end

    // mesh products follow the sides: sxy_reg is registered from side_x and side_y, tot_reg from sxy_reg and side_z
    always_comb
    begin
        sxy_next   = pmi_pkg::SXY_W'(side_x_reg) * pmi_pkg::SXY_W'(side_y_reg);
        tot_next   = pmi_pkg::TOT_W'(sxy_reg) * pmi_pkg::TOT_W'(side_z_reg);
        recip_x    = pmi_pkg::recip_of(side_x_reg);
        recip_y    = pmi_pkg::recip_of(side_y_reg);
        valid_next = {valid_reg[pmi_pkg::LATENCY-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxy_reg   <= pmi_pkg::SXY_W'(1);
            tot_reg   <= pmi_pkg::TOT_W'(1);
            valid_reg <= '0;
        end
        else
        begin
            sxy_reg   <= sxy_next;
            tot_reg   <= tot_next;
            valid_reg <= valid_next;
        end
    end

    // range check against the mesh size
    always_comb
    begin
        ctl_s3_next.op  = op_s2_reg;
        ctl_s3_next.bad = (op_s2_reg == pmi_pkg::OP_BAD)
                       || (pmi_pkg::TOT_W'(a_s2_reg) >= tot_reg)
                       || ((op_s2_reg != pmi_pkg::OP_NEG)
                           && (pmi_pkg::TOT_W'(b_s2_reg) >= tot_reg))
                       || ((op_s2_reg == pmi_pkg::OP_SUM)
                           && (pmi_pkg::TOT_W'(c_s2_reg) >= tot_reg));
    end

    always_ff @(posedge clk)
    begin
        op_s1_reg  <= pmi_pkg::op_t'(opcode);
        a_s1_reg   <= idx_a;
        b_s1_reg   <= idx_b;
        c_s1_reg   <= idx_c;
        op_s2_reg  <= op_s1_reg;
        a_s2_reg   <= a_s1_reg;
        b_s2_reg   <= b_s1_reg;
        c_s2_reg   <= c_s1_reg;
        ctl_s3_reg <= ctl_s3_next;
        ctl_s4_reg <= ctl_s3_reg;
    end

    pmi_split u_split_a (
        .clk     (clk),
        .idx     (idx_a),
        .side_x  (side_x_reg),
        .side_y  (side_y_reg),
        .recip_x (recip_x),
        .recip_y (recip_y),
        .coord   (coord_a)
    );

    pmi_split u_split_b (
        .clk     (clk),
        .idx     (idx_b),
        .side_x  (side_x_reg),
        .side_y  (side_y_reg),
        .recip_x (recip_x),
        .recip_y (recip_y),
        .coord   (coord_b)
    );

    pmi_split u_split_c (
        .clk     (clk),
        .idx     (idx_c),
        .side_x  (side_x_reg),
        .side_y  (side_y_reg),
        .recip_x (recip_x),
        .recip_y (recip_y),
        .coord   (coord_c)
    );

    pmi_combine u_combine (
        .clk          (clk),
        .side_x       (side_x_reg),
        .side_y       (side_y_reg),
        .side_z       (side_z_reg),
        .side_xy      (sxy_reg),
        .ctl          (ctl_s4_reg),
        .ca           (coord_a),
        .cb           (coord_b),
        .cc           (coord_c),
        .result_index (result_index),
        .invalid      (invalid)
    );

    assign done = valid_reg[pmi_pkg::LATENCY-1];

endmodule

`default_nettype wire

/* hdl/pmi_split.sv */
`default_nettype none

// splits one linear index into x, y, z over four register stages
module pmi_split (
    input  wire logic                             clk,
    input  wire logic [pmi_pkg::IDX_W-1:0]        idx,
    input  wire logic [pmi_pkg::SIDE_W-1:0]       side_x,
    input  wire logic [pmi_pkg::SIDE_W-1:0]       side_y,
    input  wire logic [pmi_pkg::RECIP_W-1:0]      recip_x,
    input  wire logic [pmi_pkg::RECIP_W-1:0]      recip_y,
    output pmi_pkg::coord_t                       coord
);

    logic [pmi_pkg::IDX_W-1:0]  n1_reg, n2_reg;
    logic [pmi_pkg::PROD_W-1:0] p1_reg, p1_next;
    logic [pmi_pkg::IDX_W-1:0]  q2_reg, q2_next;
    logic [pmi_pkg::MUL_W-1:0]  qx2_reg, qx2_next;
    logic [pmi_pkg::PROD_W-1:0] pq2_reg, pq2_next;
    logic [pmi_pkg::IDX_W-1:0]  q3_reg;
    logic [pmi_pkg::IDX_W-1:0]  z_full;
    logic [pmi_pkg::SIDE_W-1:0] x3_reg, x3_next;
    logic [pmi_pkg::SIDE_W-1:0] z3_reg;
    logic [pmi_pkg::MUL_W-1:0]  zy3_reg, zy3_next;
    logic [pmi_pkg::IDX_W-1:0]  y_diff;
    logic [pmi_pkg::SIDE_W-1:0] x4_reg, y4_reg, y4_next, z4_reg;

    always_comb
    begin
        // quotient by side_x through the reciprocal, then the remainder and the same split by side_y
        p1_next  = pmi_pkg::PROD_W'(idx) * pmi_pkg::PROD_W'(recip_x);
        q2_next  = p1_reg[pmi_pkg::RECIP_SHIFT +: pmi_pkg::IDX_W];
        qx2_next = pmi_pkg::MUL_W'(q2_next) * pmi_pkg::MUL_W'(side_x);
        pq2_next = pmi_pkg::PROD_W'(q2_next) * pmi_pkg::PROD_W'(recip_y);
        x3_next  = pmi_pkg::SIDE_W'(n2_reg - qx2_reg[pmi_pkg::IDX_W-1:0]);
        z_full   = pq2_reg[pmi_pkg::RECIP_SHIFT +: pmi_pkg::IDX_W];
        zy3_next = pmi_pkg::MUL_W'(z_full) * pmi_pkg::MUL_W'(side_y);
        y_diff   = q3_reg - zy3_reg[pmi_pkg::IDX_W-1:0];
        y4_next  = y_diff[pmi_pkg::SIDE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        n1_reg  <= idx;
        p1_reg  <= p1_next;
        n2_reg  <= n1_reg;
        q2_reg  <= q2_next;
        qx2_reg <= qx2_next;
        pq2_reg <= pq2_next;
        x3_reg  <= x3_next;
        q3_reg  <= q2_reg;
        z3_reg  <= z_full[pmi_pkg::SIDE_W-1:0];
        zy3_reg <= zy3_next;
        x4_reg  <= x3_reg;
        y4_reg  <= y4_next;
        z4_reg  <= z3_reg;
    end

    assign coord.x = x4_reg;
    assign coord.y = y4_reg;
    assign coord.z = z4_reg;

endmodule

`default_nettype wire

/* hdl/pmi_combine.sv */
`default_nettype none

// per-axis wrap and recombination into a linear index, two register stages
module pmi_combine (
    input  wire logic                         clk,
    input  wire logic [pmi_pkg::SIDE_W-1:0]   side_x,
    input  wire logic [pmi_pkg::SIDE_W-1:0]   side_y,
    input  wire logic [pmi_pkg::SIDE_W-1:0]   side_z,
    input  wire logic [pmi_pkg::SXY_W-1:0]    side_xy,
    input  pmi_pkg::ctl_t                     ctl,
    input  pmi_pkg::coord_t                   ca,
    input  pmi_pkg::coord_t                   cb,
    input  pmi_pkg::coord_t                   cc,
    output logic [pmi_pkg::IDX_W-1:0]         result_index,
    output logic                              invalid
);

    function automatic logic [pmi_pkg::SIDE_W-1:0] wrap_axis(
        input pmi_pkg::op_t               op,
        input logic [pmi_pkg::SIDE_W-1:0] a,
        input logic [pmi_pkg::SIDE_W-1:0] b,
        input logic [pmi_pkg::SIDE_W-1:0] c,
        input logic [pmi_pkg::SIDE_W-1:0] s
    );
        logic [6:0] v;
        logic [6:0] s7;
        s7 = 7'(s);
        case (op)
            pmi_pkg::OP_NEG:  v = s7 - 7'(a);
            pmi_pkg::OP_DIFF: v = 7'(b) + s7 - 7'(a);
            default:          v = 7'(a) + 7'(b) + s7 - 7'(c);
        endcase
        // value stays below three sides
        if (v >= s7)
            v = v - s7;
        if (v >= s7)
            v = v - s7;
        return v[pmi_pkg::SIDE_W-1:0];
    endfunction

    logic [pmi_pkg::SIDE_W-1:0] rx_reg, ry_reg, rz_reg;
    logic [pmi_pkg::SIDE_W-1:0] rx_next, ry_next, rz_next;
    logic                       bad_reg;
    logic [pmi_pkg::SUM_W-1:0]  lin_sum;
    logic [pmi_pkg::IDX_W-1:0]  result_reg, result_next;
    logic                       invalid_reg;

    always_comb
    begin
        rx_next = wrap_axis(ctl.op, ca.x, cb.x, cc.x, side_x);
        ry_next = wrap_axis(ctl.op, ca.y, cb.y, cc.y, side_y);
        rz_next = wrap_axis(ctl.op, ca.z, cb.z, cc.z, side_z);
        lin_sum = pmi_pkg::SUM_W'(rx_reg)
                + pmi_pkg::SUM_W'(ry_reg) * pmi_pkg::SUM_W'(side_x)
                + pmi_pkg::SUM_W'(rz_reg) * pmi_pkg::SUM_W'(side_xy);
        result_next = bad_reg ? '0 : lin_sum[pmi_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rz_reg      <= rz_next;
        bad_reg     <= ctl.bad;
        result_reg  <= result_next;
        invalid_reg <= bad_reg;
    end

    assign result_index = result_reg;
    assign invalid      = invalid_reg;

endmodule

`default_nettype wire

/* hdl/pmi_checker.sv */
`default_nettype none

`include "periodic_mesh_index_alu_core_assert.svh"

module pmi_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [1:0]                    opcode,
    input wire logic                          done,
    input wire logic [pmi_pkg::IDX_W-1:0]     result_index,
    input wire logic                          invalid
);

    // every transfer gives a result after the fixed latency
    `PMI_ASSERT_DLY(a_result_follows, clk, rst_n, start && !busy, pmi_pkg::LATENCY, done)

    // no result without a matching transfer
    `PMI_ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(start && !busy, pmi_pkg::LATENCY))

    `PMI_ASSERT_IMP(a_invalid_zero, clk, rst_n, done && invalid, result_index == '0)

    `PMI_ASSERT_DLY(a_unused_op, clk, rst_n, start && !busy && opcode == pmi_pkg::OP_BAD, pmi_pkg::LATENCY, done && invalid)

endmodule

bind periodic_mesh_index_alu_core pmi_checker u_pmi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .done         (done),
    .result_index (result_index),
    .invalid      (invalid)
);

`default_nettype wire
